// ===== hw/rtl/kscf_pkg.sv =====
// ----------------------------------------------------------------------------
// kscf_pkg
// Shared types and constants for the keyed secret cache: item words, the
// operation codes and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package kscf_pkg;

  localparam int unsigned WordBits    = 64;
  localparam int unsigned KeyBytes    = 32;
  localparam int unsigned KeyBits     = 8 * KeyBytes;
  localparam int unsigned SecretBytes = 32;
  localparam int unsigned SecretBits  = 256;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_IDLE   = 2'd3
  } kscf_func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECTED  = 2'd2
  } kscf_status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_READ,
    DP_NEXT,
    DP_HIT,
    DP_WR_AT,
    DP_APPEND,
    DP_SH_INIT,
    DP_SH_WR,
    DP_EVICT,
    DP_TRIM
  } kscf_op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] secret_in0;
    logic [63:0] secret_in1;
    logic [63:0] secret_in2;
    logic [63:0] secret_in3;
  } kscf_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] secret_out0;
    logic [63:0] secret_out1;
    logic [63:0] secret_out2;
    logic [63:0] secret_out3;
    logic [3:0]  entries_used;
    logic        evicted;
  } kscf_out_t;

  typedef struct packed {
    kscf_op_e     op;
    logic         out_load;
    kscf_status_e status;
    logic         evicted;
    logic         sec_sel;
  } kscf_cmd_t;

  typedef struct packed {
    kscf_func_e func;
    logic       scan_end;
    logic       key_match;
    logic       hit;
    logic       key_empty;
    logic       full;
  } kscf_sts_t;

endpackage

// ===== hw/rtl/kscf_ram.sv =====
// ----------------------------------------------------------------------------
// kscf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kscf_ram #(
  parameter int unsigned WIDTH = 512,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kscf_datapath.sv =====
// ----------------------------------------------------------------------------
// kscf_datapath
// Holds the current word, the entry table in RAM, the scan index, the entry
// count and the result register. Carries out one controller command a cycle.
// ----------------------------------------------------------------------------
module kscf_datapath import kscf_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kscf_in_t  in_word_i,
  input  kscf_cmd_t cmd_i,
  output kscf_sts_t sts_o,
  output kscf_out_t out_word_o
);

  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EntW  = KeyBits + SecretBits;
  localparam logic [CntW-1:0]  SlotsCnt = CntW'(SLOTS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(SLOTS - 1);

  kscf_func_e            func_q;
  logic [KeyBits-1:0]    key_q;
  logic [SecretBits-1:0] sec_q;
  logic [SecretBits-1:0] found_q;
  logic [AddrW-1:0]      at_q;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  hit_q, hit_d;
  kscf_out_t             out_q;

  logic [KeyBits-1:0]    in_key, key_norm;
  logic [SecretBits-1:0] in_sec, sec_masked;
  logic                  ended;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;

  assign in_key = {in_word_i.key_word3, in_word_i.key_word2,
                   in_word_i.key_word1, in_word_i.key_word0};
  assign in_sec = {in_word_i.secret_in3, in_word_i.secret_in2,
                   in_word_i.secret_in1, in_word_i.secret_in0};

  // key ends at its first zero byte
  always_comb begin
    ended = 1'b0;
    key_norm = '0;
    for (int b = 0; b < KeyBytes; b++) begin
      if (in_key[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      key_norm[8*b +: 8] = ended ? 8'h00 : in_key[8*b +: 8];
    end
  end

  always_comb begin
    sec_masked = '0;
    for (int b = 0; b < SecretBits / 8; b++) begin
      if (b < SecretBytes) begin
        sec_masked[8*b +: 8] = in_sec[8*b +: 8];
      end
    end
  end

  kscf_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = at_q;
    ram_wdata = {key_q, sec_q};
    ram_raddr = idx_q[AddrW-1:0];
    idx_d     = idx_q;
    count_d   = count_q;
    hit_d     = hit_q;
    unique case (cmd_i.op)
      DP_LOAD: begin
        idx_d = '0;
        hit_d = 1'b0;
      end
      DP_READ: begin
        ram_re = 1'b1;
      end
      DP_NEXT: begin
        idx_d = idx_q + CntW'(1);
      end
      DP_HIT: begin
        hit_d = 1'b1;
      end
      DP_WR_AT: begin
        ram_we = 1'b1;
      end
      DP_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count_q[AddrW-1:0];
        count_d   = count_q + CntW'(1);
      end
      DP_SH_INIT: begin
        idx_d = (func_q == FUNC_STORE) ? CntW'(1) : CntW'(at_q) + CntW'(1);
      end
      DP_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AddrW'(idx_q - CntW'(1));
        ram_wdata = ram_rdata;
        idx_d     = idx_q + CntW'(1);
      end
      DP_EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = LastAddr;
      end
      DP_TRIM: begin
        ram_we    = 1'b1;
        ram_waddr = AddrW'(count_q - CntW'(1));
        ram_wdata = '0;
        count_d   = count_q - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
      hit_q   <= 1'b0;
      func_q  <= FUNC_IDLE;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
      hit_q   <= hit_d;
      if (cmd_i.op == DP_LOAD) begin
        func_q <= kscf_func_e'(in_word_i.func);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      key_q <= key_norm;
      sec_q <= sec_masked;
    end
    if (cmd_i.op == DP_HIT) begin
      at_q    <= idx_q[AddrW-1:0];
      found_q <= ram_rdata[SecretBits-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.status;
      out_q.secret_out0  <= cmd_i.sec_sel ? found_q[0*WordBits +: WordBits] : '0;
      out_q.secret_out1  <= cmd_i.sec_sel ? found_q[1*WordBits +: WordBits] : '0;
      out_q.secret_out2  <= cmd_i.sec_sel ? found_q[2*WordBits +: WordBits] : '0;
      out_q.secret_out3  <= cmd_i.sec_sel ? found_q[3*WordBits +: WordBits] : '0;
      out_q.entries_used <= 4'(count_q);
      out_q.evicted      <= cmd_i.evicted;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.scan_end  = (idx_q == count_q);
  assign sts_o.key_match = (ram_rdata[EntW-1 -: KeyBits] == key_q);
  assign sts_o.hit       = hit_q;
  assign sts_o.key_empty = (key_q[7:0] == 8'h00);
  assign sts_o.full      = (count_q == SlotsCnt);

  assign out_word_o = out_q;

endmodule

// ===== hw/rtl/kscf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kscf_ctrl
// Sequencer for the keyed secret cache: accepts a word, scans the table,
// decides the action, runs the shift pass and hands the result to the output.
// ----------------------------------------------------------------------------
module kscf_ctrl import kscf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  kscf_sts_t sts_i,
  output kscf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ACT,
    S_SH_RD,
    S_SH_WR,
    S_TAIL,
    S_DONE
  } state_e;

  state_e       state_q, state_d;
  kscf_status_e status_q, status_d;
  logic         evicted_q, evicted_d;
  logic         sec_sel_q, sec_sel_d;
  logic         out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    evicted_d     = evicted_q;
    sec_sel_d     = sec_sel_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.op       = DP_NOP;
    cmd_o.out_load = 1'b0;
    cmd_o.status   = status_q;
    cmd_o.evicted  = evicted_q;
    cmd_o.sec_sel  = sec_sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op  = DP_LOAD;
          status_d  = ST_OK;
          evicted_d = 1'b0;
          sec_sel_d = 1'b0;
          state_d   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = S_ACT;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.key_match) begin
          cmd_o.op = DP_HIT;
          state_d  = S_ACT;
        end else begin
          cmd_o.op = DP_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_ACT: begin
        state_d = S_DONE;
        unique case (sts_i.func)
          FUNC_LOOKUP: begin
            status_d  = sts_i.hit ? ST_OK : ST_NOT_FOUND;
            sec_sel_d = sts_i.hit;
          end
          FUNC_STORE: begin
            priority if (sts_i.key_empty) begin
              status_d = ST_REJECTED;
            end else if (sts_i.hit) begin
              cmd_o.op = DP_WR_AT;
            end else if (sts_i.full) begin
              cmd_o.op  = DP_SH_INIT;
              evicted_d = 1'b1;
              state_d   = S_SH_RD;
            end else begin
              cmd_o.op = DP_APPEND;
            end
          end
          FUNC_REMOVE: begin
            if (sts_i.hit) begin
              cmd_o.op = DP_SH_INIT;
              state_d  = S_SH_RD;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_SH_RD: begin
        if (sts_i.scan_end) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = DP_SH_WR;
        state_d  = S_SH_RD;
      end
      S_TAIL: begin
        cmd_o.op = (sts_i.func == FUNC_STORE) ? DP_EVICT : DP_TRIM;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      evicted_q   <= 1'b0;
      sec_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      evicted_q   <= evicted_d;
      sec_sel_q   <= sec_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/keyed_secret_cache_fifo_evict.sv =====
// ----------------------------------------------------------------------------
// keyed_secret_cache_fifo_evict
// Fully associative cache of 256-bit keys to 256-bit secrets, FIFO eviction.
//
// in channel: in_valid_i / in_stall_o carry one request word: func (lookup,
// store, remove), a zero-padded key and, for a store, the secret. A word is
// taken when in_valid_i is high and in_stall_o is low.
// out channel: out_valid_o / out_stall_i carry one result word per request:
// status, the secret on a lookup hit, the entry count and an eviction flag.
// The table lives in a single-port-read RAM of SLOTS entries. A request scans
// the valid entries until a key matches; a store of a new key into a full
// table or a remove of a present key then moves the later entries down.
// One request is in flight at a time, and the next is taken once the current
// result has gone to the output register.
// Reset empties the table at once; no clearing pass is run.
// While the receiver stalls, the result word is held and the block stalls
// its input once a further result is ready.
// ----------------------------------------------------------------------------
module keyed_secret_cache_fifo_evict import kscf_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  kscf_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output kscf_out_t out_word_o
);

  kscf_cmd_t cmd;
  kscf_sts_t sts;

  kscf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kscf_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyed_secret_cache_fifo_evict. A directed table
// covers empty and full tables, empty keys, bytes after a key terminator,
// updates in place, removal from the middle, eviction and the unused
// operation. A random part follows, using a small key pool so that hits,
// updates, removals and evictions keep recurring. Every result word is
// checked field by field against a typed row's want or a behavioural model
// of the table held here, with random request idling and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import kscf_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned POOL        = 12;
  localparam int unsigned RAND_ITEMS  = 1000;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN       = 4 * SLOTS + 8;
  localparam int unsigned IN_BITS     = $bits(kscf_in_t);

  localparam logic [255:0] KEY_A       = 256'h61;
  localparam logic [255:0] KEY_B       = 256'h4241;
  localparam logic [255:0] KEY_B_DIRTY = (~256'h0 << 24) | 256'h4241;
  localparam logic [255:0] KEY_FULL    = ~256'h0;
  localparam logic [255:0] KEY_EMPTY   = 256'h0;
  localparam logic [255:0] KEY_EMPTY_D = ~256'hff;
  localparam logic [255:0] SEC_ONES    = ~256'h0;
  localparam logic [255:0] SEC_PAT     = {4{64'h0123_4567_89ab_cdef}};

  typedef struct {
    kscf_in_t  req;
    bit        typed;
    kscf_out_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  kscf_in_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  kscf_out_t out_word_o;

  logic [255:0] key_tab    [SLOTS];
  logic [255:0] secret_tab [SLOTS];
  int           fill;
  kscf_out_t    due_results [$];
  dir_row_t     dir_rows [$];
  logic [255:0] key_pool [POOL];
  int           mismatches;
  int           quiet_cycles;
  bit           steady;

  keyed_secret_cache_fifo_evict #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // key ends at its first zero byte
  function automatic logic [255:0] trim_key(input logic [255:0] raw);
    logic [255:0] k;
    bit           ended;
    int           i;
    k     = '0;
    ended = 1'b0;
    for (i = 0; i < 32; i++) begin
      if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic logic [255:0] dirty_tail(input logic [255:0] k);
    logic [255:0] d;
    bit           ended;
    int           i;
    d     = k;
    ended = 1'b0;
    for (i = 0; i < 32; i++) begin
      if (ended) d[8*i +: 8] = 8'($urandom);
      if (k[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return d;
  endfunction

  function automatic logic [255:0] random_key(input int len);
    logic [255:0] k;
    int           i;
    k = '0;
    for (i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  function automatic kscf_in_t make_request(input kscf_func_e func, input logic [255:0] key,
                                            input logic [255:0] secret);
    kscf_in_t r;
    r.func = func;
    {r.key_word3, r.key_word2, r.key_word1, r.key_word0}     = key;
    {r.secret_in3, r.secret_in2, r.secret_in1, r.secret_in0} = secret;
    return r;
  endfunction

  function automatic kscf_out_t cache_access(input kscf_in_t req);
    kscf_out_t    res;
    logic [255:0] key;
    logic [255:0] secret;
    int           hit_at;
    int           slot;
    int           i;
    key    = trim_key({req.key_word3, req.key_word2, req.key_word1, req.key_word0});
    secret = {req.secret_in3, req.secret_in2, req.secret_in1, req.secret_in0};
    for (i = SecretBytes; i < 32; i++) secret[8*i +: 8] = 8'h00;
    hit_at = -1;
    for (i = 0; i < fill; i++) begin
      if (hit_at < 0 && key_tab[i] == key) hit_at = i;
    end
    res = '0;
    case (kscf_func_e'(req.func))
      FUNC_LOOKUP: begin
        if (hit_at >= 0) begin
          {res.secret_out3, res.secret_out2, res.secret_out1, res.secret_out0} =
            secret_tab[hit_at];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FUNC_STORE: begin
        if (key[7:0] == 8'h00) begin
          res.status = ST_REJECTED;
        end else begin
          if (hit_at >= 0) begin
            slot = hit_at;
          end else if (fill >= SLOTS) begin
            for (i = 1; i < SLOTS; i++) begin
              key_tab[i-1]    = key_tab[i];
              secret_tab[i-1] = secret_tab[i];
            end
            slot        = SLOTS - 1;
            res.evicted = 1'b1;
          end else begin
            slot = fill;
            fill++;
          end
          key_tab[slot]    = key;
          secret_tab[slot] = secret;
        end
      end
      FUNC_REMOVE: begin
        if (hit_at >= 0) begin
          for (i = hit_at + 1; i < fill; i++) begin
            key_tab[i-1]    = key_tab[i];
            secret_tab[i-1] = secret_tab[i];
          end
          fill--;
          key_tab[fill]    = '0;
          secret_tab[fill] = '0;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.entries_used = 4'(fill);
    return res;
  endfunction

  task automatic add_row(input kscf_func_e func, input logic [255:0] key,
                         input logic [255:0] secret, input bit typed,
                         input kscf_status_e st, input logic [3:0] used, input logic ev);
    dir_row_t row;
    row.req              = make_request(func, key, secret);
    row.typed            = typed;
    row.want             = '0;
    row.want.status      = st;
    row.want.entries_used = used;
    row.want.evicted     = ev;
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input kscf_in_t req, input bit typed, input kscf_out_t want);
    kscf_out_t res;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      in_word_i  <= IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    res = cache_access(req);
    due_results.push_back(typed ? want : res);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 23);
  end

  // result word check
  always @(posedge clk_i) begin
    kscf_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_word_o));
      end else begin
        want = due_results.pop_front();
        if (out_word_o.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_word_o.status, want.status));
        if (out_word_o.secret_out0 !== want.secret_out0)
          report_mismatch($sformatf("secret_out0 %h, want %h", out_word_o.secret_out0,
                                    want.secret_out0));
        if (out_word_o.secret_out1 !== want.secret_out1)
          report_mismatch($sformatf("secret_out1 %h, want %h", out_word_o.secret_out1,
                                    want.secret_out1));
        if (out_word_o.secret_out2 !== want.secret_out2)
          report_mismatch($sformatf("secret_out2 %h, want %h", out_word_o.secret_out2,
                                    want.secret_out2));
        if (out_word_o.secret_out3 !== want.secret_out3)
          report_mismatch($sformatf("secret_out3 %h, want %h", out_word_o.secret_out3,
                                    want.secret_out3));
        if (out_word_o.entries_used !== want.entries_used)
          report_mismatch($sformatf("entries_used %0d, want %0d", out_word_o.entries_used,
                                    want.entries_used));
        if (out_word_o.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, want %b", out_word_o.evicted, want.evicted));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    kscf_in_t     req;
    kscf_out_t    none;
    logic [255:0] key;
    logic [255:0] secret;
    int           n;
    int           roll;
    kscf_func_e   func;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_word_i    <= '0;
    out_stall_i  <= 1'b0;
    quiet_cycles  = 0;
    mismatches    = 0;
    steady        = 1'b0;
    fill          = 0;
    none          = '0;
    for (n = 0; n < SLOTS; n++) begin
      key_tab[n]    = '0;
      secret_tab[n] = '0;
    end
    for (n = 0; n < POOL; n++) key_pool[n] = random_key($urandom_range(32, 1));

    add_row(FUNC_LOOKUP, KEY_A,       SEC_PAT,  1, ST_NOT_FOUND, 4'd0, 1'b0);
    add_row(FUNC_REMOVE, KEY_A,       SEC_PAT,  1, ST_NOT_FOUND, 4'd0, 1'b0);
    add_row(FUNC_IDLE,   KEY_A,       SEC_PAT,  1, ST_OK,        4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_EMPTY,   SEC_PAT,  1, ST_REJECTED,  4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_EMPTY_D, SEC_ONES, 1, ST_REJECTED,  4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_A,       SEC_ONES, 1, ST_OK,        4'd1, 1'b0);
    add_row(FUNC_LOOKUP, KEY_A,       '0,       0, ST_OK,        4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_B_DIRTY, SEC_PAT,  1, ST_OK,        4'd2, 1'b0);
    add_row(FUNC_LOOKUP, KEY_B,       '0,       0, ST_OK,        4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_FULL,    '0,       1, ST_OK,        4'd3, 1'b0);
    add_row(FUNC_LOOKUP, KEY_FULL,    SEC_ONES, 0, ST_OK,        4'd0, 1'b0);
    add_row(FUNC_STORE,  KEY_A,       SEC_PAT,  1, ST_OK,        4'd3, 1'b0);
    add_row(FUNC_LOOKUP, KEY_EMPTY,   '0,       1, ST_NOT_FOUND, 4'd3, 1'b0);
    add_row(FUNC_REMOVE, KEY_EMPTY,   '0,       1, ST_NOT_FOUND, 4'd3, 1'b0);
    add_row(FUNC_REMOVE, KEY_B,       '0,       1, ST_OK,        4'd2, 1'b0);
    add_row(FUNC_LOOKUP, KEY_FULL,    '0,       0, ST_OK,        4'd0, 1'b0);
    for (n = 0; n < 6; n++) begin
      add_row(FUNC_STORE, 256'h70 + n, SEC_PAT ^ n, 1, ST_OK, 4'(3 + n), 1'b0);
    end
    // table full: oldest entry goes
    add_row(FUNC_STORE,  KEY_B,       SEC_ONES, 1, ST_OK,        4'd8, 1'b1);
    add_row(FUNC_LOOKUP, KEY_A,       '0,       1, ST_NOT_FOUND, 4'd8, 1'b0);
    add_row(FUNC_IDLE,   KEY_B,       SEC_ONES, 1, ST_OK,        4'd8, 1'b0);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (n = 0; n < RAND_ITEMS; n++) begin
      steady = (n >= 400 && n < 560);
      if ($urandom_range(99) < 4) key_pool[$urandom_range(POOL - 1)] =
        random_key($urandom_range(32, 1));
      roll = $urandom_range(99);
      if (roll < 38)      func = FUNC_STORE;
      else if (roll < 72) func = FUNC_LOOKUP;
      else if (roll < 94) func = FUNC_REMOVE;
      else                func = FUNC_IDLE;
      if ($urandom_range(9) == 0) key = random_key($urandom_range(32, 0));
      else                        key = key_pool[$urandom_range(POOL - 1)];
      if ($urandom_range(3) == 0) key = dirty_tail(key);
      secret = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
      req = make_request(func, key, secret);
      send_request(req, 1'b0, none);
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== keyed_secret_cache_fifo_evict.f =====
hw/rtl/kscf_pkg.sv
hw/rtl/kscf_ram.sv
hw/rtl/kscf_datapath.sv
hw/rtl/kscf_ctrl.sv
hw/rtl/keyed_secret_cache_fifo_evict.sv
sim/tb_top.sv
